// File: rtl/paged_attribute_unpack_addresser_macros.svh
// Assertion macros for the paged attribute unpack addresser.
// Included by the top level; no other dependencies.
`ifndef PAGED_ATTRIBUTE_UNPACK_ADDRESSER_MACROS_SVH
`define PAGED_ATTRIBUTE_UNPACK_ADDRESSER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication: when a holds, c must hold.
`define PAU_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("pau assertion failed");
// Next-cycle implication: when a holds, c must hold in the next cycle.
`define PAU_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("pau assertion failed");
`else
`define PAU_ASSERT_IMP(label, clk, rst_n, a, c)
`define PAU_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/pau_pkg.sv
// Package of the paged attribute unpack addresser: sequencer states, register
// indexes, shared unit widths and the pack width selector. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pau_pkg;

	// Operand and result widths of the shared multiply-add unit.
	localparam int MAC_A_W = 32;
	localparam int MAC_B_W = 24;
	localparam int MAC_P_W = 42;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ELEMENT_COUNT   = 3'd0;
	localparam logic [2:0] CFG_TUPLE_SIZE      = 3'd1;
	localparam logic [2:0] CFG_PAGE_SIZE       = 3'd2;
	localparam logic [2:0] CFG_PACK_COUNT      = 3'd3;
	localparam logic [2:0] CFG_PACK_WIDTHS     = 3'd4;
	localparam logic [2:0] CFG_FLAGS_ENABLED   = 3'd5;
	localparam logic [2:0] CFG_COMPONENT_BYTES = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PSTART,
		ST_PAGE,
		ST_GTS,
		ST_DBASE,
		ST_SRCE,
		ST_SRCB,
		ST_WB,
		ST_EMIT,
		ST_ADV
	} pau_state_t;

	// Component count of one pack out of the packed width register.
	function automatic logic [4:0] pack_width_f(input logic [39:0] pw, input logic [2:0] idx);
		logic [4:0] w;
		w = pw[idx*5 +: 5];
		return w;
	endfunction

endpackage
`default_nettype wire

// File: rtl/pau_mac.sv
// Shared multiply-add unit of the paged attribute unpack addresser.
// Computes a * b + c, truncated to the result width. Uses pau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pau_mac (
	input  logic [pau_pkg::MAC_A_W-1:0] a,
	input  logic [pau_pkg::MAC_B_W-1:0] b,
	input  logic [pau_pkg::MAC_P_W-1:0] c,
	output logic [pau_pkg::MAC_P_W-1:0] p
);
	import pau_pkg::*;

	logic [MAC_A_W+MAC_B_W-1:0] prod;

	assign prod = a * b;
	assign p    = prod[MAC_P_W-1:0] + c;

endmodule
`default_nettype wire

// File: rtl/paged_attribute_unpack_addresser.sv
// Top level of the paged attribute unpack addresser: configuration registers,
// sequencer and datapath. Uses pau_pkg, pau_mac and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "paged_attribute_unpack_addresser_macros.svh"
// Each input word stands for the next element of a paged attribute whose tuples
// are stored split into packs, and carries that page's constant-pack flags, which
// are sampled only at the first element of a page. For every effective pack the
// block delivers one output word: a source byte offset into the packed buffer, a
// destination byte offset into the interleaved buffer and a byte count; the last
// word of an element carries last_of_element, and every word of the final element
// carries last_element, after which the block wraps back to element zero. The
// effective pack count runs from 1 to MAX_PACKS. The block takes no new element
// until the last one is through, and a word still waiting in the output stalls
// the next one. All products go through one multiply-add unit: the element is
// prepared in order (page start, page length, tuple start, destination base),
// each pack then uses the unit for its source element offset, source byte offset,
// byte count and next source position, and a last step advances the page
// state. The input is ready only while no element is in progress; an output
// register lets the block take the next element while the last word still waits.
// Configuration writes are always accepted; made while no element is in progress,
// they take effect at the next element.
module paged_attribute_unpack_addresser #(
	parameter int MAX_PACKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data,
	// Input words.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  page_flags,
	// Output words.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] source_offset,
	output logic [31:0] dest_offset,
	output logic [7:0]  copy_bytes,
	output logic        last_of_element,
	output logic        last_element
);
	import pau_pkg::*;

	localparam int PK_W = (MAX_PACKS > 1) ? $clog2(MAX_PACKS) : 1;

	// Configuration registers.
	logic [23:0] ec_q;
	logic [4:0]  ts_q;
	logic [16:0] page_size_q;
	logic [3:0]  pcnt_q;
	logic [39:0] pw_q;
	logic        fen_q;
	logic [3:0]  cb_q;

	// Walk state across elements.
	logic [23:0] page_number_q;
	logic [16:0] eip_q;
	logic [31:0] base_q;
	logic [7:0]  lflags_q;
	logic [16:0] plen_q;

	// Per-element working registers.
	pau_state_t  state_q, state_d;
	logic [PK_W-1:0] pk_q;
	logic [40:0] pstart_q;
	logic [41:0] gidx_q;
	logic        last_q;
	logic [31:0] gts_q;
	logic [31:0] db_q;
	logic [31:0] sb_q;
	logic [31:0] srce_q;
	logic [31:0] srcb_q;
	logic [8:0]  wb_q;

	// Output register.
	logic        out_valid_q;
	logic [31:0] src_out_q;
	logic [31:0] dst_out_q;
	logic [7:0]  cnt_out_q;
	logic        loe_out_q;
	logic        le_out_q;

	// Shared unit operands.
	logic [MAC_A_W-1:0] mac_a;
	logic [MAC_B_W-1:0] mac_b;
	logic [MAC_P_W-1:0] mac_c;
	logic [MAC_P_W-1:0] mac_p;

	logic        in_go;
	logic        emit_go;
	logic [16:0] psize_eff;
	logic [3:0]  npk;
	logic [2:0]  pk3;
	logic [4:0]  w;
	logic        cst;
	logic        last_pack;
	logic [41:0] left;
	logic [41:0] plen_wide;
	logic [16:0] plen_new;
	logic [16:0] plen_use;
	logic [41:0] gidx_d;
	logic        page_end;

	pau_mac u_mac (
		.a(mac_a),
		.b(mac_b),
		.c(mac_c),
		.p(mac_p)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_go     = in_valid && in_ready;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// A zero page size counts as one element per page.
	assign psize_eff = (page_size_q == 17'd0) ? 17'd1 : page_size_q;

	// An empty pack list is one pack of the whole tuple; too many packs clip.
	always_comb begin
		if (pcnt_q == 4'd0) begin
			npk = 4'd1;
		end else if (pcnt_q > 4'(MAX_PACKS)) begin
			npk = 4'(MAX_PACKS);
		end else begin
			npk = pcnt_q;
		end
	end

	assign pk3       = 3'(pk_q);
	assign w         = (pcnt_q == 4'd0) ? ts_q : pack_width_f(pw_q, pk3);
	assign cst       = lflags_q[pk3];
	assign last_pack = ((4'(pk_q) + 4'd1) == npk);

	// Page length of a page that starts here: the elements left, at most one
	// page, and one when the page starts past the end.
	assign left      = (42'(ec_q) > 42'(pstart_q)) ? (42'(ec_q) - 42'(pstart_q)) : 42'd1;
	assign plen_wide = (left < 42'(psize_eff)) ? left : 42'(psize_eff);
	assign plen_new  = (plen_wide[16:0] == 17'd0) ? 17'd1 : plen_wide[16:0];
	assign plen_use  = (eip_q == 17'd0) ? plen_new : plen_q;
	assign gidx_d    = 42'(pstart_q) + 42'(eip_q);
	assign page_end  = ((18'(eip_q) + 18'd1) >= 18'(plen_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_go) begin
					state_d = ST_PSTART;
				end
			end
			ST_PSTART: state_d = ST_PAGE;
			ST_PAGE:   state_d = ST_GTS;
			ST_GTS:    state_d = ST_DBASE;
			ST_DBASE:  state_d = ST_SRCE;
			ST_SRCE:   state_d = ST_SRCB;
			ST_SRCB:   state_d = ST_WB;
			ST_WB:     state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) begin
					state_d = last_pack ? ST_ADV : ST_SRCE;
				end
			end
			ST_ADV:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Operand selection for the shared unit in each step.
	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_c = '0;
		case (state_q)
			ST_PSTART: begin
				mac_a = MAC_A_W'(page_number_q);
				mac_b = MAC_B_W'(psize_eff);
			end
			ST_GTS: begin
				mac_a = gidx_q[31:0];
				mac_b = MAC_B_W'(ts_q);
			end
			ST_DBASE: begin
				mac_a = gts_q;
				mac_b = MAC_B_W'(cb_q);
			end
			ST_SRCE: begin
				mac_a = cst ? '0 : MAC_A_W'(eip_q);
				mac_b = MAC_B_W'(w);
				mac_c = MAC_P_W'(sb_q);
			end
			ST_SRCB: begin
				mac_a = srce_q;
				mac_b = MAC_B_W'(cb_q);
			end
			ST_WB: begin
				mac_a = MAC_A_W'(w);
				mac_b = MAC_B_W'(cb_q);
			end
			ST_EMIT: begin
				// Advance the running source position past this pack's run.
				mac_a = cst ? MAC_A_W'(1) : MAC_A_W'(plen_q);
				mac_b = MAC_B_W'(w);
				mac_c = MAC_P_W'(sb_q);
			end
			ST_ADV: begin
				mac_a = MAC_A_W'(psize_eff);
				mac_b = MAC_B_W'(ts_q);
				mac_c = MAC_P_W'(base_q);
			end
			default: begin
				mac_a = '0;
			end
		endcase
	end

	// Control state, configuration and walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ec_q          <= 24'd1;
			ts_q          <= 5'd1;
			page_size_q   <= 17'd1024;
			pcnt_q        <= 4'd1;
			pw_q          <= 40'd1;
			fen_q         <= 1'b0;
			cb_q          <= 4'd4;
			page_number_q <= '0;
			eip_q         <= '0;
			base_q        <= '0;
			lflags_q      <= '0;
			plen_q        <= '0;
			pk_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ELEMENT_COUNT:   ec_q        <= cfg_data[23:0];
					CFG_TUPLE_SIZE:      ts_q        <= cfg_data[4:0];
					CFG_PAGE_SIZE:       page_size_q <= cfg_data[16:0];
					CFG_PACK_COUNT:      pcnt_q      <= cfg_data[3:0];
					CFG_PACK_WIDTHS:     pw_q        <= cfg_data;
					CFG_FLAGS_ENABLED:   fen_q       <= cfg_data[0];
					CFG_COMPONENT_BYTES: cb_q        <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			// The flags are sampled only at the first element of a page.
			if (in_go && (eip_q == 17'd0)) begin
				lflags_q <= fen_q ? page_flags : 8'd0;
			end
			if (state_q == ST_PAGE) begin
				plen_q <= plen_use;
			end
			if (state_q == ST_DBASE) begin
				pk_q <= '0;
			end
			if (emit_go && !last_pack) begin
				pk_q <= pk_q + PK_W'(1);
			end
			if (state_q == ST_ADV) begin
				if (last_q) begin
					page_number_q <= '0;
					eip_q         <= '0;
					base_q        <= '0;
					lflags_q      <= '0;
					plen_q        <= '0;
				end else if (page_end) begin
					// With flags the running source position already is the
					// next page's base; without, a page is a full page of tuples.
					base_q        <= fen_q ? sb_q : mac_p[31:0];
					page_number_q <= page_number_q + 24'd1;
					eip_q         <= '0;
				end else begin
					eip_q <= eip_q + 17'd1;
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PSTART: pstart_q <= mac_p[40:0];
			ST_PAGE: begin
				gidx_q <= gidx_d;
				last_q <= ((gidx_d + 42'd1) >= 42'(ec_q));
			end
			ST_GTS:    gts_q <= mac_p[31:0];
			ST_DBASE: begin
				db_q <= mac_p[31:0];
				sb_q <= base_q;
			end
			ST_SRCE:   srce_q <= mac_p[31:0];
			ST_SRCB:   srcb_q <= mac_p[31:0];
			ST_WB:     wb_q <= mac_p[8:0];
			ST_EMIT: begin
				if (emit_go) begin
					sb_q      <= mac_p[31:0];
					db_q      <= db_q + 32'(wb_q);
					src_out_q <= srcb_q;
					dst_out_q <= db_q;
					cnt_out_q <= wb_q[7:0];
					loe_out_q <= last_pack;
					le_out_q  <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign source_offset   = src_out_q;
	assign dest_offset     = dst_out_q;
	assign copy_bytes      = cnt_out_q;
	assign last_of_element = loe_out_q;
	assign last_element    = le_out_q;

	// The element index never reaches the latched page length during pack work.
	`PAU_ASSERT_IMP(a_eip_in_page, clk, arst_n, (state_q == ST_SRCE), (eip_q < plen_q))
	// The pack counter stays below the effective pack count.
	`PAU_ASSERT_IMP(a_pack_in_range, clk, arst_n, (state_q == ST_EMIT), (4'(pk_q) < npk))
	// After the final element the walk state is back at element zero.
	`PAU_ASSERT_NEXT(a_wrap_clears, clk, arst_n, ((state_q == ST_ADV) && last_q),
		((page_number_q == 24'd0) && (eip_q == 17'd0) && (base_q == 32'd0)))

endmodule
`default_nettype wire
